/* sv/pmpt_pkg.sv */
// Shared types and constants for the PS/2 mouse packet tracker.
// No dependencies.
package pmpt_pkg;

    localparam int CFG_W      = 13;
    localparam int OUT_W      = 12;
    localparam int BTN_W      = 3;
    localparam int IDX_W      = 4;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd1280;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd800;
    localparam logic [31:0]      CUR_X_INIT = 32'd640;
    localparam logic [31:0]      CUR_Y_INIT = 32'd400;

    localparam int HDR_SYNC_BIT = 3;
    localparam int HDR_XOVF_BIT = 6;
    localparam int HDR_YOVF_BIT = 7;

    localparam logic [IDX_W-1:0] REG_SCREEN_WIDTH  = 4'd0;
    localparam logic [IDX_W-1:0] REG_SCREEN_HEIGHT = 4'd1;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_phase;

    typedef struct packed {
        logic [7:0]       dx;
        logic [7:0]       dy;
        logic [BTN_W-1:0] buttons;
    } t_packet;

endpackage

/* sv/pmpt_framer.sv */
// Byte framer: groups received bytes into three-byte packets and holds
// the completed packet in the input register. Depends on pmpt_pkg.
module pmpt_framer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_take,
    output logic              o_pkt_valid,
    output pmpt_pkg::t_packet o_pkt
);
    import pmpt_pkg::*;

    t_phase     r_phase, n_phase;
    logic [7:0] r_header, n_header;
    logic [7:0] r_xbyte, n_xbyte;
    logic       r_pkt_valid, n_pkt_valid;
    t_packet    r_pkt, n_pkt;
    logic       accept;

    assign o_ready     = !r_pkt_valid || i_take;
    assign accept      = i_valid && o_ready;
    assign o_pkt_valid = r_pkt_valid;
    assign o_pkt       = r_pkt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pkt_valid <= 1'b0;
            r_header    <= 8'd0;
            r_xbyte     <= 8'd0;
        end else begin
            r_phase     <= n_phase;
            r_pkt_valid <= n_pkt_valid;
            r_header    <= n_header;
            r_xbyte     <= n_xbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pkt <= n_pkt;
    end

    always_comb begin
        n_phase     = r_phase;
        n_header    = r_header;
        n_xbyte     = r_xbyte;
        n_pkt       = r_pkt;
        n_pkt_valid = r_pkt_valid && !i_take;
        if (accept) begin
            case (r_phase)
                PH_XDELTA: begin
                    n_xbyte = i_byte;
                    n_phase = PH_YDELTA;
                end
                PH_YDELTA: begin
                    n_phase     = PH_HEADER;
                    n_pkt_valid = 1'b1;
                    n_pkt.dx    = r_header[HDR_XOVF_BIT] ? 8'd0 : r_xbyte;
                    n_pkt.dy    = r_header[HDR_YOVF_BIT] ? 8'd0 : i_byte;
                    n_pkt.buttons = r_header[BTN_W-1:0];
                end
                default: begin
                    n_header = i_byte;
                    n_phase  = i_byte[HDR_SYNC_BIT] ? PH_XDELTA : PH_HEADER;
                end
            endcase
        end
    end

endmodule

/* sv/pmpt_clamp.sv */
// Single coordinate update: add or subtract a signed delta and clamp to the screen.
// Depends on pmpt_pkg.
module pmpt_clamp #(
    parameter int CB = pmpt_pkg::COORD_BITS_DEF
) (
    input  logic [CB-1:0]              i_cur,
    input  logic [7:0]                 i_delta,
    input  logic                       i_sub,
    input  logic [pmpt_pkg::CFG_W-1:0] i_size,
    output logic [CB-1:0]              o_cur
);
    import pmpt_pkg::*;

    localparam int SW  = CB + 2;
    localparam int SZW = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;

    logic signed [SW-1:0] d_ext;
    logic signed [SW-1:0] sum;
    logic [SZW-1:0]       size_ext;
    logic [SZW-1:0]       cap;
    logic [SZW-1:0]       lim_m1_w;
    logic [CB-1:0]        lim_m1;

    assign d_ext    = SW'($signed(i_delta));
    assign sum      = i_sub ? $signed({2'b00, i_cur}) - d_ext
                            : $signed({2'b00, i_cur}) + d_ext;
    assign size_ext = SZW'(i_size);
    assign cap      = SZW'(1) << CB;

    always_comb begin
        if (size_ext == '0) begin
            lim_m1_w = '0;
        end else if (size_ext > cap) begin
            lim_m1_w = cap - SZW'(1);
        end else begin
            lim_m1_w = size_ext - SZW'(1);
        end
        lim_m1 = lim_m1_w[CB-1:0];
        if (sum < 0) begin
            o_cur = '0;
        end else if (sum > $signed({2'b00, lim_m1})) begin
            o_cur = lim_m1;
        end else begin
            o_cur = sum[CB-1:0];
        end
    end

endmodule

/* sv/pmpt_cursor.sv */
// Cursor state and result register: applies one packet per cycle unless the output stalls.
// Depends on pmpt_pkg and pmpt_clamp.
module pmpt_cursor #(
    parameter int CB = pmpt_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_pkt_valid,
    input  pmpt_pkg::t_packet          i_pkt,
    output logic                       o_take,
    input  logic [pmpt_pkg::CFG_W-1:0] i_width,
    input  logic [pmpt_pkg::CFG_W-1:0] i_height,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [pmpt_pkg::OUT_W-1:0] o_pos_x,
    output logic [pmpt_pkg::OUT_W-1:0] o_pos_y,
    output logic [pmpt_pkg::BTN_W-1:0] o_buttons
);
    import pmpt_pkg::*;

    logic [CB-1:0]        r_cur_x, r_cur_y;
    logic [CB-1:0]        n_cur_x, n_cur_y;
    logic                 r_valid;
    logic [OUT_W-1:0]     r_pos_x, r_pos_y;
    logic [BTN_W-1:0]     r_buttons;
    logic [OUT_W+CB-1:0]  x_ext, y_ext;

    assign o_take = i_pkt_valid && (!r_valid || i_ready);

    pmpt_clamp #(.CB(CB)) u_clamp_x (
        .i_cur   (r_cur_x),
        .i_delta (i_pkt.dx),
        .i_sub   (1'b0),
        .i_size  (i_width),
        .o_cur   (n_cur_x)
    );

    pmpt_clamp #(.CB(CB)) u_clamp_y (
        .i_cur   (r_cur_y),
        .i_delta (i_pkt.dy),
        .i_sub   (1'b1),
        .i_size  (i_height),
        .o_cur   (n_cur_y)
    );

    assign x_ext = {{OUT_W{1'b0}}, n_cur_x};
    assign y_ext = {{OUT_W{1'b0}}, n_cur_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cur_x <= CUR_X_INIT[CB-1:0];
            r_cur_y <= CUR_Y_INIT[CB-1:0];
        end else begin
            if (o_take) begin
                r_valid <= 1'b1;
                r_cur_x <= n_cur_x;
                r_cur_y <= n_cur_y;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_pos_x   <= x_ext[OUT_W-1:0];
            r_pos_y   <= y_ext[OUT_W-1:0];
            r_buttons <= i_pkt.buttons;
        end
    end

    assign o_valid   = r_valid;
    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_buttons = r_buttons;

endmodule

/* sv/ps2_mouse_packet_tracker_unit.sv */
// PS/2 mouse packet tracker top level: screen-size registers, framer and
// cursor stage. Depends on pmpt_pkg, pmpt_framer and pmpt_cursor.
// Takes one received mouse byte per cycle unless the output stalls. Every
// third byte of a packet whose header has bit 3 set yields one result via
// the packet and result registers: the clamped pointer position and the
// button bits. Each register holds one item, so input and output can run
// back to back at one item per cycle. Write screen size only while idle.
module ps2_mouse_packet_tracker_unit #(
    parameter int COORD_BITS = pmpt_pkg::COORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pmpt_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [pmpt_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_rx_valid,
    output logic                       o_rx_ready,
    input  logic [7:0]                 i_rx_byte,
    output logic                       o_pos_valid,
    input  logic                       i_pos_ready,
    output logic [pmpt_pkg::OUT_W-1:0] o_pos_x,
    output logic [pmpt_pkg::OUT_W-1:0] o_pos_y,
    output logic [pmpt_pkg::BTN_W-1:0] o_button_bits
);
    import pmpt_pkg::*;

    logic [CFG_W-1:0] r_width, r_height;
    logic             pkt_valid;
    t_packet          pkt;
    logic             take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    pmpt_framer u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_rx_valid),
        .o_ready     (o_rx_ready),
        .i_byte      (i_rx_byte),
        .i_take      (take),
        .o_pkt_valid (pkt_valid),
        .o_pkt       (pkt)
    );

    pmpt_cursor #(.CB(COORD_BITS)) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (pkt_valid),
        .i_pkt       (pkt),
        .o_take      (take),
        .i_width     (r_width),
        .i_height    (r_height),
        .o_valid     (o_pos_valid),
        .i_ready     (i_pos_ready),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_buttons   (o_button_bits)
    );

endmodule
